// ===== sv/rhsi_pkg.sv =====
// Shared types and constants of the RGB to HSI pixel pipeline.
// Holds the CORDIC arctangent table and pi, both built at elaboration.
// No dependencies.
package rhsi_pkg;

  localparam int ANG_BITS     = 60;
  localparam int CORDIC_STEPS = 40;
  localparam int SQRT_ITERS   = 32;
  localparam int ROOT_STAGES  = 16;
  localparam int PIDIV_STAGES = 16;
  localparam int PIDIV_STEP   = 2;

  typedef logic [CORDIC_STEPS-1:0][63:0] atan_tab_t;

  typedef struct packed {
    logic        grey;
    logic        b_gt_g;
    logic [15:0] sat;
    logic [15:0] inten;
  } side_t;

  // Restoring long division, used only while the constant tables are built.
  function automatic logic [63:0] udiv64(logic [63:0] a, logic [63:0] d);
    logic [63:0] q;
    logic [64:0] r;
    q = 64'd0;
    r = 65'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], a[i]};
      if (r >= {1'b0, d}) begin
        r    = r - {1'b0, d};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [63:0] atan_inv(logic [63:0] n);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    p   = udiv64(64'd1 << ANG_BITS, n);
    sum = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = udiv64(p, 64'(2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - t;
        end else begin
          sum = sum + t;
        end
        p = udiv64(p, n * n);
      end
    end
    return sum;
  endfunction

  function automatic logic [63:0] atan_pow2(int i);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] t;
    p   = (64'd1 << ANG_BITS) >> i;
    sum = 64'd0;
    for (int k = 0; k < 64; k++) begin
      if (p != 64'd0) begin
        t = udiv64(p, 64'(2 * k + 1));
        if (k % 2 == 1) begin
          sum = sum - t;
        end else begin
          sum = sum + t;
        end
        p = (2 * i < 64) ? (p >> (2 * i)) : 64'd0;
      end
    end
    return sum;
  endfunction

  function automatic atan_tab_t build_atan_tab();
    atan_tab_t tab;
    tab[0] = (atan_inv(64'd5) << 2) - atan_inv(64'd239);
    for (int i = 1; i < CORDIC_STEPS; i++) begin
      tab[i] = atan_pow2(i);
    end
    return tab;
  endfunction

  localparam atan_tab_t   ATAN_TAB = build_atan_tab();
  localparam logic [63:0] PI_Q     = ATAN_TAB[0] << 2;

endpackage

// ===== sv/rhsi_root.sv =====
// Front end: channel sums, square root for the hue vector, and the
// saturation and intensity dividers. Depends on rhsi_pkg.
module rhsi_root #(
  parameter int UNIT_FRAC_BITS = 15
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [7:0]          red_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          blue_i,
  output logic                valid_o,
  output logic signed [63:0]  nx_o,
  output logic signed [63:0]  ny_o,
  output rhsi_pkg::side_t     side_o
);
  import rhsi_pkg::*;

  localparam int NW      = UNIT_FRAC_BITS + 12;
  localparam int DSTEP   = (NW + ROOT_STAGES - 1) / ROOT_STAGES;
  localparam int SQ_STEP = SQRT_ITERS / ROOT_STAGES;

  typedef struct packed {
    logic [63:0] v;
    logic [63:0] r;
  } sq_t;

  typedef struct packed {
    logic [10:0]   rem;
    logic [NW-1:0] n;
    logic [NW-1:0] q;
  } div_t;

  function automatic sq_t sq_step(sq_t a, int k);
    logic [63:0] b;
    logic [63:0] t;
    sq_t o;
    b = 64'd1 << (62 - 2 * k);
    t = a.r + b;
    if (a.v >= t) begin
      o.v = a.v - t;
      o.r = (a.r >> 1) + b;
    end else begin
      o.v = a.v;
      o.r = a.r >> 1;
    end
    return o;
  endfunction

  function automatic div_t div_step(div_t a, logic [10:0] d);
    logic [11:0] r2;
    div_t o;
    r2  = {a.rem, a.n[NW-1]};
    o.n = a.n << 1;
    if (r2 >= {1'b0, d}) begin
      o.rem = 11'(r2 - {1'b0, d});
      o.q   = {a.q[NW-2:0], 1'b1};
    end else begin
      o.rem = r2[10:0];
      o.q   = {a.q[NW-2:0], 1'b0};
    end
    return o;
  endfunction

  logic [9:0]         sum;
  logic [7:0]         mn;
  logic [7:0]         dd;
  logic signed [10:0] diff;
  logic [17:0]        sq3;

  sq_t                sq_q   [ROOT_STAGES+1];
  div_t               ds_q   [ROOT_STAGES+1];
  div_t               di_q   [ROOT_STAGES+1];
  logic [10:0]        dsv_q  [ROOT_STAGES+1];
  logic signed [63:0] nx_q   [ROOT_STAGES+1];
  logic               grey_q [ROOT_STAGES+1];
  logic               bgg_q  [ROOT_STAGES+1];
  logic               valid_q[ROOT_STAGES+1];

  always_comb begin
    sum  = 10'(red_i) + 10'(green_i) + 10'(blue_i);
    mn   = (red_i < green_i) ? red_i : green_i;
    mn   = (blue_i < mn) ? blue_i : mn;
    dd   = (green_i > blue_i) ? (green_i - blue_i) : (blue_i - green_i);
    diff = $signed({2'b00, red_i, 1'b0}) - $signed({3'b000, green_i})
         - $signed({3'b000, blue_i});
    sq3  = 18'(16'(dd) * 16'(dd)) * 18'd3;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      grey_q[0]   <= (red_i == green_i) && (green_i == blue_i);
      bgg_q[0]    <= blue_i > green_i;
      nx_q[0]     <= {{53{diff[10]}}, diff} <<< 34;
      sq_q[0].v   <= 64'(sq3) << 44;
      sq_q[0].r   <= 64'd0;
      ds_q[0].rem <= 11'd0;
      ds_q[0].n   <= (NW'(sum - 10'(11'(mn) * 11'd3)) << (UNIT_FRAC_BITS + 1)) + NW'(sum);
      ds_q[0].q   <= '0;
      dsv_q[0]    <= ((red_i == green_i) && (green_i == blue_i)) ? 11'd1 : {sum, 1'b0};
      di_q[0].rem <= 11'd0;
      di_q[0].n   <= (NW'(sum) << UNIT_FRAC_BITS) + NW'(382);
      di_q[0].q   <= '0;
    end
  end

  for (genvar s = 0; s < ROOT_STAGES; s++) begin : g_stage
    sq_t  sq_c;
    div_t ds_c;
    div_t di_c;

    always_comb begin
      sq_c = sq_q[s];
      ds_c = ds_q[s];
      di_c = di_q[s];
      for (int j = 0; j < SQ_STEP; j++) begin
        sq_c = sq_step(sq_c, s * SQ_STEP + j);
      end
      for (int j = 0; j < DSTEP; j++) begin
        if (s * DSTEP + j < NW) begin
          ds_c = div_step(ds_c, dsv_q[s]);
          di_c = div_step(di_c, 11'd765);
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sq_q[s+1]   <= sq_c;
        ds_q[s+1]   <= ds_c;
        di_q[s+1]   <= di_c;
        dsv_q[s+1]  <= dsv_q[s];
        nx_q[s+1]   <= nx_q[s];
        grey_q[s+1] <= grey_q[s];
        bgg_q[s+1]  <= bgg_q[s];
      end
    end
  end

  assign valid_o      = valid_q[ROOT_STAGES];
  assign nx_o         = nx_q[ROOT_STAGES];
  assign ny_o         = $signed({sq_q[ROOT_STAGES].r[51:0], 12'd0});
  assign side_o.grey  = grey_q[ROOT_STAGES];
  assign side_o.b_gt_g = bgg_q[ROOT_STAGES];
  assign side_o.sat   = grey_q[ROOT_STAGES] ? 16'd0 : ds_q[ROOT_STAGES].q[15:0];
  assign side_o.inten = di_q[ROOT_STAGES].q[15:0];

endmodule

// ===== sv/rhsi_cordic.sv =====
// Vectoring CORDIC, one micro-rotation per stage, giving the angle of the
// hue vector in Q60 radians. Depends on rhsi_pkg.
module rhsi_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [63:0] nx_i,
  input  logic signed [63:0] ny_i,
  input  rhsi_pkg::side_t    side_i,
  output logic               valid_o,
  output logic signed [63:0] z_o,
  output rhsi_pkg::side_t    side_o
);
  import rhsi_pkg::*;

  function automatic logic signed [63:0] shr_tz(logic signed [63:0] a, int s);
    logic signed [63:0] m;
    m = (64'sd1 <<< s) - 64'sd1;
    if (a < 64'sd0) begin
      return (a + m) >>> s;
    end else begin
      return a >>> s;
    end
  endfunction

  logic signed [63:0] x_q    [CORDIC_STEPS+1];
  logic signed [63:0] y_q    [CORDIC_STEPS+1];
  logic signed [63:0] z_q    [CORDIC_STEPS+1];
  side_t              side_q [CORDIC_STEPS+1];
  logic               valid_q[CORDIC_STEPS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      if (nx_i < 64'sd0) begin
        x_q[0] <= ny_i;
        y_q[0] <= -nx_i;
        z_q[0] <= $signed(ATAN_TAB[0] << 1);
      end else begin
        x_q[0] <= nx_i;
        y_q[0] <= ny_i;
        z_q[0] <= 64'sd0;
      end
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    logic signed [63:0] xs;
    logic signed [63:0] ys;

    always_comb begin
      xs = shr_tz(x_q[i], i);
      ys = shr_tz(y_q[i], i);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[i+1] <= valid_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[i+1] <= side_q[i];
        if (y_q[i] > 64'sd0) begin
          x_q[i+1] <= x_q[i] + ys;
          y_q[i+1] <= y_q[i] - xs;
          z_q[i+1] <= z_q[i] + $signed(ATAN_TAB[i]);
        end else begin
          x_q[i+1] <= x_q[i] - ys;
          y_q[i+1] <= y_q[i] + xs;
          z_q[i+1] <= z_q[i] - $signed(ATAN_TAB[i]);
        end
      end
    end
  end

  assign valid_o = valid_q[CORDIC_STEPS];
  assign z_o     = z_q[CORDIC_STEPS];
  assign side_o  = side_q[CORDIC_STEPS];

endmodule

// ===== sv/rhsi_hue.sv =====
// Back end: clamps the angle, divides it by pi, scales to degrees, mirrors or
// zeroes the hue; holds the output register. Depends on rhsi_pkg.
module rhsi_hue #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [63:0] z_i,
  input  rhsi_pkg::side_t    side_i,
  output logic               valid_o,
  output logic [14:0]        hue_o,
  output logic [15:0]        saturation_o,
  output logic [15:0]        intensity_o
);
  import rhsi_pkg::*;

  localparam int MW = HUE_FRAC_BITS + 8;
  localparam int HW = HUE_FRAC_BITS + 10;
  localparam int PW = 33 + MW;
  localparam logic [MW-1:0] HALF_TURN = MW'(180) << HUE_FRAC_BITS;
  localparam logic [HW-1:0] FULL_TURN = HW'(360) << HUE_FRAC_BITS;

  logic [63:0] ang;
  logic [63:0] rem_q  [PIDIV_STAGES+1];
  logic [32:0] q_q    [PIDIV_STAGES+1];
  side_t       side_q [PIDIV_STAGES+1];
  logic        valid_q[PIDIV_STAGES+1];

  logic [PW-1:0] prod_q;
  side_t         mside_q;
  logic          mvalid_q;
  logic [PW-1:0] rnd;
  logic [HW-1:0] hraw;
  logic [HW-1:0] hsel;

  always_comb begin
    if (z_i < 64'sd0) begin
      ang = 64'd0;
    end else if ($unsigned(z_i) > PI_Q) begin
      ang = PI_Q;
    end else begin
      ang = $unsigned(z_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q[0] <= 1'b0;
    end else if (en_i) begin
      valid_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0] <= side_i;
      if (ang >= PI_Q) begin
        rem_q[0] <= ang - PI_Q;
        q_q[0]   <= 33'd1;
      end else begin
        rem_q[0] <= ang;
        q_q[0]   <= 33'd0;
      end
    end
  end

  for (genvar s = 0; s < PIDIV_STAGES; s++) begin : g_div
    logic [63:0] rem_c;
    logic [32:0] q_c;

    always_comb begin
      rem_c = rem_q[s];
      q_c   = q_q[s];
      for (int j = 0; j < PIDIV_STEP; j++) begin
        rem_c = rem_c << 1;
        q_c   = q_c << 1;
        if (rem_c >= PI_Q) begin
          rem_c  = rem_c - PI_Q;
          q_c[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s+1] <= 1'b0;
      end else if (en_i) begin
        valid_q[s+1] <= valid_q[s];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[s+1]  <= rem_c;
        q_q[s+1]    <= q_c;
        side_q[s+1] <= side_q[s];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
      valid_o  <= 1'b0;
    end else if (en_i) begin
      mvalid_q <= valid_q[PIDIV_STAGES];
      valid_o  <= mvalid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q  <= PW'(q_q[PIDIV_STAGES]) * PW'(HALF_TURN);
      mside_q <= side_q[PIDIV_STAGES];
    end
  end

  always_comb begin
    rnd  = prod_q + (PW'(1) << 31);
    hraw = HW'(rnd >> 32);
    if (mside_q.grey) begin
      hsel = '0;
    end else if (mside_q.b_gt_g) begin
      hsel = FULL_TURN - hraw;
    end else begin
      hsel = hraw;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hue_o        <= 15'(hsel);
      saturation_o <= mside_q.sat;
      intensity_o  <= mside_q.inten;
    end
  end

endmodule

// ===== sv/rgb_to_hsi_pixel_unit.sv =====
// Top level of the RGB to HSI pixel converter.
// Depends on rhsi_pkg, rhsi_root, rhsi_cordic and rhsi_hue.
//
// Channel | Signals                                   | Direction
// input   | in_valid_i, in_ready_o, red/green/blue_i  | request in
// output  | out_valid_o, out_ready_i, hue/sat/int_o   | request out
//
// One request is taken every cycle while the output is not stalled. The
// pipeline holds the 40-stage CORDIC and the stages of the square root and of
// the divisions; the square root and the saturation and intensity divisions share stages.
// Reset clears only the valid bits of the pipeline.
// The whole pipeline holds while a result waits and the output is stalled.
module rgb_to_hsi_pixel_unit #(
  parameter int HUE_FRAC_BITS  = 6,
  parameter int UNIT_FRAC_BITS = 15
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  red_i,
  input  logic [7:0]  green_i,
  input  logic [7:0]  blue_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [14:0] hue_o,
  output logic [15:0] saturation_o,
  output logic [15:0] intensity_o
);
  import rhsi_pkg::*;

  logic               en;
  logic               rt_valid;
  logic signed [63:0] rt_nx;
  logic signed [63:0] rt_ny;
  side_t              rt_side;
  logic               cd_valid;
  logic signed [63:0] cd_z;
  side_t              cd_side;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  rhsi_root #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .red_i   (red_i),
    .green_i (green_i),
    .blue_i  (blue_i),
    .valid_o (rt_valid),
    .nx_o    (rt_nx),
    .ny_o    (rt_ny),
    .side_o  (rt_side)
  );

  rhsi_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (rt_valid),
    .nx_i    (rt_nx),
    .ny_i    (rt_ny),
    .side_i  (rt_side),
    .valid_o (cd_valid),
    .z_o     (cd_z),
    .side_o  (cd_side)
  );

  rhsi_hue #(.HUE_FRAC_BITS(HUE_FRAC_BITS)) u_hue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .valid_i      (cd_valid),
    .z_i          (cd_z),
    .side_i       (cd_side),
    .valid_o      (out_valid_o),
    .hue_o        (hue_o),
    .saturation_o (saturation_o),
    .intensity_o  (intensity_o)
  );

endmodule

// ===== sv/rhsi_checker.sv =====
// Port-level checker for rgb_to_hsi_pixel_unit and its bind statement.
// Depends only on the top level's ports and its UNIT_FRAC_BITS parameter.
module rhsi_checker #(
  parameter int UNIT_FRAC_BITS = 15
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [14:0] hue_o,
  input logic [15:0] saturation_o,
  input logic [15:0] intensity_o
);

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Output request dropped while stalled.");

  a_out_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(hue_o) && $stable(saturation_o) && $stable(intensity_o))
    else $error("Output payload changed while stalled.");

  a_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("Input ready does not follow the output stall.");

  if (UNIT_FRAC_BITS >= 10 && UNIT_FRAC_BITS < 16) begin : g_grey
    a_grey_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && saturation_o == 16'd0 |-> hue_o == 15'd0)
      else $error("Hue is not zero for a pixel without saturation.");
  end

endmodule

bind rgb_to_hsi_pixel_unit rhsi_checker #(.UNIT_FRAC_BITS(UNIT_FRAC_BITS)) u_rhsi_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hue_o        (hue_o),
  .saturation_o (saturation_o),
  .intensity_o  (intensity_o)
);
